>>> design/pcxrle_pkg.sv
package pcxrle_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CountW = 6;
  localparam int unsigned ClassW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0]  RunMark      = 8'hC0;
  localparam logic [ByteW-1:0]  RunMask      = 8'h3F;
  localparam logic [ByteW-1:0]  DitherFirst  = 8'd224;
  localparam logic [ByteW-1:0]  TranspIndex  = 8'd255;
  localparam logic [PosW-1:0]   LineBytesRst = 16'd640;
  localparam logic [PosW-1:0]   VisWidthRst  = 16'd640;

  localparam logic [CfgIdxW-1:0] CfgLineBytes = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgVisWidth  = 1'b1;

  localparam logic [ClassW-1:0] ClsNormal  = 2'd0;
  localparam logic [ClassW-1:0] ClsImplant = 2'd1;
  localparam logic [ClassW-1:0] ClsDither  = 2'd2;
  localparam logic [ClassW-1:0] ClsTransp  = 2'd3;

  localparam logic [ByteW-1:0] AlphaClear  = 8'd0;
  localparam logic [ByteW-1:0] AlphaDither = 8'd128;
  localparam logic [ByteW-1:0] AlphaOpaque = 8'd255;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [ByteW-1:0]  alpha;
  } pix_attr_t;

  typedef struct packed {
    logic            line_end;
    logic [PosW-1:0] next_pos;
    logic            overflow;
  } pos_res_t;

  function automatic pix_attr_t classify(input logic [ByteW-1:0] pix);
    pix_attr_t a;
    logic [3:0] row;
    row = pix[7:4];
    if (pix == TranspIndex) begin
      a.cls   = ClsTransp;
      a.alpha = AlphaClear;
    end else if ((row == 4'd0) || ((row <= 4'd3) && !pix[0])) begin
      a.cls   = ClsImplant;
      a.alpha = AlphaOpaque;
    end else if (pix >= DitherFirst) begin
      a.cls   = ClsDither;
      a.alpha = AlphaDither;
    end else begin
      a.cls   = ClsNormal;
      a.alpha = AlphaOpaque;
    end
    return a;
  endfunction

endpackage

>>> design/pcxrle_pos_unit.sv
module pcxrle_pos_unit (
  input  logic [pcxrle_pkg::PosW-1:0]   pos_i,
  input  logic [pcxrle_pkg::PosW-1:0]   line_bytes_i,
  input  logic [pcxrle_pkg::CountW-1:0] count_i,
  output pcxrle_pkg::pos_res_t          res_o
);
  import pcxrle_pkg::*;

  logic [PosW:0]   pos_inc;
  logic [PosW-1:0] room;
  logic            at_end;

  // one incrementer and one subtractor shared by the check and emit steps
  assign pos_inc = {1'b0, pos_i} + {{PosW{1'b0}}, 1'b1};
  assign at_end  = pos_inc >= {1'b0, line_bytes_i};
  assign room    = line_bytes_i - pos_i;

  assign res_o.line_end = at_end;
  assign res_o.next_pos = at_end ? '0 : pos_inc[PosW-1:0];
  assign res_o.overflow = at_end ? (count_i > CountW'(1))
                                 : ({{(PosW-CountW){1'b0}}, count_i} > room);

endmodule

>>> design/pcx_rle_scanline_decoder_unit.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_ready_o   | code_byte_i
// out     | output    | out_valid_o/out_ready_i | pixel_index_o .. last_o
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
// a run marker byte, or a run value byte of zero count, gives no word
// a literal byte or a run value byte of nonzero count passes the check state,
// then emits one pixel word per cycle unless the output stalls
// the output register lets the next byte be taken while the final word waits
// reset clears the sequencer, run state, line position and error flag
module pcx_rle_scanline_decoder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcxrle_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pcxrle_pkg::PosW-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pcxrle_pkg::ByteW-1:0]    code_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pcxrle_pkg::ByteW-1:0]    pixel_index_o,
  output logic [pcxrle_pkg::PosW-1:0]     column_o,
  output logic                            visible_o,
  output logic [pcxrle_pkg::ClassW-1:0]   pixel_class_o,
  output logic [pcxrle_pkg::ByteW-1:0]    alpha_o,
  output logic                            line_end_o,
  output logic                            overflow_error_o,
  output logic                            last_o
);
  import pcxrle_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic              awaiting_q;
  logic [CountW-1:0] pending_q;
  logic [PosW-1:0]   pos_q;
  logic              err_q;
  logic [ByteW-1:0]  pix_q;
  logic [CountW-1:0] rem_q;
  logic [PosW-1:0]   line_bytes_q;
  logic [PosW-1:0]   vis_width_q;

  logic              out_valid_q;
  logic [ByteW-1:0]  out_pix_q;
  logic [PosW-1:0]   out_col_q;
  logic              out_vis_q;
  pix_attr_t         out_attr_q;
  logic              out_end_q;
  logic              out_err_q;
  logic              out_last_q;

  pos_res_t  pos_res;
  pix_attr_t attr;
  logic      in_fire;
  logic      out_load;
  logic      is_marker;
  logic      final_word;

  pcxrle_pos_unit u_pos (
    .pos_i        (pos_q),
    .line_bytes_i (line_bytes_q),
    .count_i      (rem_q),
    .res_o        (pos_res)
  );

  assign attr       = classify(pix_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_marker  = ((code_byte_i & RunMark) == RunMark);
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign final_word = pos_res.line_end || (rem_q == CountW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      awaiting_q   <= 1'b0;
      pending_q    <= '0;
      pos_q        <= '0;
      err_q        <= 1'b0;
      rem_q        <= '0;
      line_bytes_q <= LineBytesRst;
      vis_width_q  <= VisWidthRst;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLineBytes: line_bytes_q <= cfg_wdata_i;
          CfgVisWidth:  vis_width_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (awaiting_q) begin
              awaiting_q <= 1'b0;
              pending_q  <= '0;
              rem_q      <= pending_q;
              if (pending_q != '0) begin
                state_q <= S_CHECK;
              end
            end else if (is_marker) begin
              awaiting_q <= 1'b1;
              pending_q  <= CountW'(code_byte_i & RunMask);
            end else begin
              rem_q   <= CountW'(1);
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (pos_res.overflow) begin
            err_q <= 1'b1;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            pos_q       <= pos_res.next_pos;
            rem_q       <= rem_q - CountW'(1);
            if (final_word) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q <= code_byte_i;
    end
    if (out_load) begin
      out_pix_q  <= pix_q;
      out_col_q  <= pos_q;
      out_vis_q  <= (pos_q < vis_width_q);
      out_attr_q <= attr;
      out_end_q  <= pos_res.line_end;
      out_err_q  <= err_q;
      out_last_q <= final_word;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_index_o    = out_pix_q;
  assign column_o         = out_col_q;
  assign visible_o        = out_vis_q;
  assign pixel_class_o    = out_attr_q.cls;
  assign alpha_o          = out_attr_q.alpha;
  assign line_end_o       = out_end_q;
  assign overflow_error_o = out_err_q;
  assign last_o           = out_last_q;

endmodule

>>> design/pcxrle_checker.sv
module pcxrle_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [pcxrle_pkg::ByteW-1:0]    pixel_index_o,
  input logic [pcxrle_pkg::PosW-1:0]     column_o,
  input logic [pcxrle_pkg::ClassW-1:0]   pixel_class_o,
  input logic [pcxrle_pkg::ByteW-1:0]    alpha_o,
  input logic                            line_end_o,
  input logic                            last_o
);
  import pcxrle_pkg::*;

  // stalled word keeps its place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pixel_index_o) && $stable(column_o)
      && $stable(last_o) && $stable(line_end_o))
    else $error("output word changed while stalled");

  // class and alpha must agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pixel_class_o == ClsTransp) == (alpha_o == AlphaClear))
      && ((pixel_class_o == ClsDither) == (alpha_o == AlphaDither)))
    else $error("alpha does not match pixel class");

  // a run never continues past the end of a line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_end_o |-> last_o)
    else $error("line end word is not the final word of its byte");

endmodule

bind pcx_rle_scanline_decoder_unit pcxrle_checker u_pcxrle_checker (.*);
